/* sv/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, types and field helpers for the time-slice scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int FIELD_W   = 3;
  localparam int PACK_W    = 24;
  localparam int RUN_W     = 4;
  localparam int IDX_W     = $clog2(NUM_TASKS + 1);
  localparam int SLOT_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int EXT_W     = (FIELD_W * NUM_TASKS > PACK_W) ? FIELD_W * NUM_TASKS : PACK_W;

  localparam logic [FIELD_W-1:0] VAL_MIN    = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] VAL_MAX    = FIELD_W'(5);
  localparam logic [PACK_W-1:0]  PRIO_RESET = PACK_W'(2396745);

  typedef struct packed {
    logic start;
    logic dec;
    logic scan;
    logic pick;
    logic reload;
    logic finish;
  } pts_cmd_t;

  typedef struct packed {
    logic run_idle;
    logic need_pick;
    logic idx_last;
    logic best_none;
    logic out_busy;
  } pts_stat_t;

  function automatic logic [SLOT_W-1:0] task_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] s;
    s = idx - IDX_W'(1);
    return s[SLOT_W-1:0];
  endfunction

  // 3-bit field of one task, clamped to 1..5; fields above the packed word read 0
  function automatic logic [FIELD_W-1:0] field_clamp(input logic [PACK_W-1:0] packed_w,
                                                     input logic [SLOT_W-1:0] slot);
    logic [EXT_W-1:0]   ext;
    logic [FIELD_W-1:0] v;
    ext = EXT_W'(packed_w);
    v   = ext[FIELD_W*slot +: FIELD_W];
    if (v < VAL_MIN) v = VAL_MIN;
    if (v > VAL_MAX) v = VAL_MAX;
    return v;
  endfunction

endpackage

/* sv/priority_timeslice_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_timeslice_scheduler
// Priority time-slice scheduler: one request per timer tick, one result each.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | in_refill_counts
//   out     | out_valid / out_ready| out_running_task, out_switched,
//           |                      | out_remaining_slice, out_reloaded
//   cfg     | cfg_wr_en            | cfg_wr_data (task priorities)
//
// One request at a time. A tick decrements the running task's slice; when it
// reaches zero, or from the idle task, a priority scan picks the next task.
// With no task ready, a reload sweep and a second scan follow (one task per
// cycle through the scan and the reload sweep). Any out_ready stall holds the tick in its result handoff.
// The result register frees the input side: in_ready returns while a result waits.
// Reset is synchronous; it clears all slice counts and selects the idle task.
// ----------------------------------------------------------------------------
module priority_timeslice_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pts_pkg::PACK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pts_pkg::PACK_W-1:0]    in_refill_counts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pts_pkg::RUN_W-1:0]     out_running_task,
  output logic                          out_switched,
  output logic [pts_pkg::FIELD_W-1:0]   out_remaining_slice,
  output logic                          out_reloaded
);
  import pts_pkg::*;

  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pts_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_refill_counts    (in_refill_counts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_running_task    (out_running_task),
    .out_switched        (out_switched),
    .out_remaining_slice (out_remaining_slice),
    .out_reloaded        (out_reloaded),
    .cmd                 (cmd),
    .stat                (stat)
  );

endmodule

/* sv/pts_ctrl.sv */
// ----------------------------------------------------------------------------
// pts_ctrl
// Tick sequencer: decrement, priority scan, reload sweep, result handoff.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t  cmd
);
  import pts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DEC    = 6'b000010,
    S_SCAN   = 6'b000100,
    S_EVAL   = 6'b001000,
    S_RELOAD = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = stat.run_idle ? S_SCAN : S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = stat.need_pick ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.idx_last) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.best_none) begin
          state_nxt = S_RELOAD;
        end else begin
          cmd.pick  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RELOAD: begin
        cmd.reload = 1'b1;
        if (stat.idx_last) state_nxt = S_SCAN;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* sv/pts_dp.sv */
// ----------------------------------------------------------------------------
// pts_dp
// Slice counters, priority register, scan pointer, best-pick and output regs.
// ----------------------------------------------------------------------------
module pts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pts_pkg::PACK_W-1:0]    cfg_wr_data,
  input  logic [pts_pkg::PACK_W-1:0]    in_refill_counts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pts_pkg::RUN_W-1:0]     out_running_task,
  output logic                          out_switched,
  output logic [pts_pkg::FIELD_W-1:0]   out_remaining_slice,
  output logic                          out_reloaded,
  input  pts_pkg::pts_cmd_t             cmd,
  output pts_pkg::pts_stat_t            stat
);
  import pts_pkg::*;

  logic [FIELD_W-1:0] cnt_r [NUM_TASKS];
  logic [PACK_W-1:0]  prio_r;
  logic [PACK_W-1:0]  refill_r;
  logic [IDX_W-1:0]   run_r, new_run_r, idx_r, best_r;
  logic [FIELD_W-1:0] best_prio_r, best_cnt_r, rem_r;
  logic               reloaded_r;
  logic               out_valid_r, out_sw_r, out_rl_r;
  logic [RUN_W-1:0]   out_run_r;
  logic [FIELD_W-1:0] out_rem_r;

  logic [SLOT_W-1:0]  rd_slot, idx_slot;
  logic [FIELD_W-1:0] rd_cnt, dec_cnt, cur_prio;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_slot;
  logic [FIELD_W-1:0] wr_data;
  logic               idx_last;
  logic [IDX_W-1:0]   idx_nxt;

  assign idx_slot = task_slot(idx_r);
  assign rd_slot  = cmd.dec ? task_slot(run_r) : idx_slot;
  assign rd_cnt   = cnt_r[rd_slot];
  assign dec_cnt  = (rd_cnt != '0) ? rd_cnt - FIELD_W'(1) : '0;
  assign cur_prio = field_clamp(prio_r, idx_slot);
  assign idx_last = (idx_r == IDX_W'(NUM_TASKS));
  assign idx_nxt  = idx_last ? IDX_W'(1) : idx_r + IDX_W'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_slot = rd_slot;
    wr_data = dec_cnt;
    if (cmd.dec) begin
      wr_en = 1'b1;
    end else if (cmd.reload) begin
      wr_en   = 1'b1;
      wr_slot = idx_slot;
      wr_data = field_clamp(refill_r, idx_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) cnt_r[i] <= '0;
    end else if (wr_en) begin
      cnt_r[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r      <= PRIO_RESET;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) prio_r <= cfg_wr_data;
      if (cmd.finish) begin
        run_r       <= new_run_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      refill_r    <= in_refill_counts;
      new_run_r   <= run_r;
      idx_r       <= IDX_W'(1);
      best_r      <= '0;
      best_prio_r <= '0;
      best_cnt_r  <= '0;
      reloaded_r  <= 1'b0;
    end
    if (cmd.dec) rem_r <= dec_cnt;
    if (cmd.scan) begin
      idx_r <= idx_nxt;
      if (rd_cnt != '0 && cur_prio > best_prio_r) begin
        best_r      <= idx_r;
        best_prio_r <= cur_prio;
        best_cnt_r  <= rd_cnt;
      end
    end
    if (cmd.reload) begin
      idx_r <= idx_nxt;
      if (idx_last) reloaded_r <= 1'b1;
    end
    if (cmd.pick) begin
      new_run_r <= best_r;
      rem_r     <= best_cnt_r;
    end
    if (cmd.finish) begin
      out_run_r <= RUN_W'(new_run_r);
      out_sw_r  <= (new_run_r != run_r);
      out_rem_r <= rem_r;
      out_rl_r  <= reloaded_r;
    end
  end

  assign stat.run_idle  = (run_r == '0);
  assign stat.need_pick = (dec_cnt == '0);
  assign stat.idx_last  = idx_last;
  assign stat.best_none = (best_r == '0);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_running_task    = out_run_r;
  assign out_switched        = out_sw_r;
  assign out_remaining_slice = out_rem_r;
  assign out_reloaded        = out_rl_r;

endmodule

/* sv/pts_checker.sv */
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pts_pkg::RUN_W-1:0]     out_running_task,
  input  logic                          out_switched,
  input  logic [pts_pkg::FIELD_W-1:0]   out_remaining_slice,
  input  logic                          out_reloaded
);
  import pts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_running_task)
      && $stable(out_remaining_slice) && $stable(out_switched) && $stable(out_reloaded))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_user_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_running_task != '0
      && 32'(out_running_task) <= NUM_TASKS)
    else $error("tick ended without a user task running");

  a_slice_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_remaining_slice >= VAL_MIN && out_remaining_slice <= VAL_MAX)
    else $error("remaining slice out of range");

endmodule

bind priority_timeslice_scheduler pts_checker u_pts_checker (.*);

/* dv/sched_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sched_checker
// Watches the tick and result channels of the time-slice scheduler. Keeps
// its own copy of the priorities, slice counts and running task, predicts
// the result of every accepted tick, and compares each returned result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sched_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pts_pkg::PACK_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [pts_pkg::PACK_W-1:0]  in_refill_counts,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [pts_pkg::RUN_W-1:0]   out_running_task,
  input  logic                        out_switched,
  input  logic [pts_pkg::FIELD_W-1:0] out_remaining_slice,
  input  logic                        out_reloaded,
  output int                          fail_count,
  output int                          pending,
  output int                          checked,
  output int                          reloads,
  output int                          switches
);
  import pts_pkg::*;

  typedef struct packed {
    logic [RUN_W-1:0]   running;
    logic               switched;
    logic [FIELD_W-1:0] remaining;
    logic               reloaded;
  } pick_t;

  logic [PACK_W-1:0]  prio_word = PRIO_RESET;
  logic [FIELD_W-1:0] slices [0:NUM_TASKS];
  logic [RUN_W-1:0]   current = '0;
  pick_t              queued_picks [$];
  int                 errs = 0;
  int                 n_checked = 0;
  int                 n_reloads = 0;
  int                 n_switches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    reloads    = 0;
    switches   = 0;
  end

  // per-task 3-bit field, limited to 1..5; bits above the word read as zero
  function automatic logic [FIELD_W-1:0] unpack_field(input logic [PACK_W-1:0] word,
                                                      input int t);
    logic [63:0]        wide;
    logic [FIELD_W-1:0] v;
    wide = 64'(word) >> (FIELD_W * (t - 1));
    v    = wide[FIELD_W-1:0];
    if (v < VAL_MIN) v = VAL_MIN;
    else if (v > VAL_MAX) v = VAL_MAX;
    return v;
  endfunction

  function automatic int best_ready_task();
    int best;
    int best_prio;
    best      = 0;
    best_prio = 0;
    for (int t = 1; t <= NUM_TASKS; t++) begin
      if (slices[t] != 0 && int'(unpack_field(prio_word, t)) > best_prio) begin
        best_prio = int'(unpack_field(prio_word, t));
        best      = t;
      end
    end
    return best;
  endfunction

  function automatic pick_t tick_scheduler(input logic [PACK_W-1:0] refill);
    pick_t r;
    int    prev;
    int    chosen;
    logic  need;
    prev       = int'(current);
    r.reloaded = 1'b0;
    if (current == 0 || current > NUM_TASKS) begin
      need = 1'b1;
    end else begin
      if (slices[current] != 0) slices[current] = slices[current] - 1'b1;
      need = (slices[current] == 0);
    end
    if (need) begin
      chosen = best_ready_task();
      if (chosen == 0) begin
        for (int t = 1; t <= NUM_TASKS; t++) slices[t] = unpack_field(refill, t);
        r.reloaded = 1'b1;
        chosen     = best_ready_task();
      end
      current = RUN_W'(chosen);
    end
    r.running   = current;
    r.switched  = (int'(current) != prev);
    r.remaining = (current <= NUM_TASKS) ? slices[current] : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    pick_t want;
    if (!rst_n) begin
      prio_word = PRIO_RESET;
      current   = '0;
      for (int t = 0; t <= NUM_TASKS; t++) slices[t] = '0;
      queued_picks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (queued_picks.size() == 0) begin
          $error("result with no request pending: task %0d", out_running_task);
          errs++;
        end else begin
          want = queued_picks.pop_front();
          check_field("running_task", 8'(want.running), 8'(out_running_task));
          check_field("switched", 8'(want.switched), 8'(out_switched));
          check_field("remaining_slice", 8'(want.remaining), 8'(out_remaining_slice));
          check_field("reloaded", 8'(want.reloaded), 8'(out_reloaded));
          n_checked++;
          if (want.reloaded) n_reloads++;
          if (want.switched) n_switches++;
        end
      end
      if (in_valid && in_ready) queued_picks.push_back(tick_scheduler(in_refill_counts));
      if (cfg_wr_en) prio_word = cfg_wr_data;
    end
    fail_count <= errs;
    pending    <= queued_picks.size();
    checked    <= n_checked;
    reloads    <= n_reloads;
    switches   <= n_switches;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the priority time-slice scheduler. A short
// directed pass covers field extremes, out-of-range priorities and refill
// counts and priority ties; then random ticks run under a series of random
// priority settings, with bursty requests, a stalling receiver and long
// receiver holds that back the block up. sched_checker does the prediction.
// ----------------------------------------------------------------------------
module testbench;
  import pts_pkg::*;

  localparam int PHASES      = 11;
  localparam int PHASE_TICKS = 150;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 40;
  localparam int FIELDS      = PACK_W / FIELD_W;
  localparam int N_DIR       = 23;

  localparam logic [PACK_W-1:0] DIR_REFILL [N_DIR] = '{
    24'h000000, 24'hFFFFFF, 24'hB6DB6D, 24'h924924, 24'h6DB6DB, 24'h249249,
    24'hFAC688, 24'h000000, 24'h000001, 24'h800000, 24'hFFFFFF,
    24'h053977, 24'h555555, 24'hAAAAAA, 24'h000000,
    24'hFFFFFF, 24'h000000, 24'hFAC688, 24'h053977, 24'hB6DB6D,
    24'h000001, 24'h924924, 24'hFFFFFF
  };
  localparam int                DIR_CUT  [4] = '{6, 11, 15, 20};
  localparam logic [PACK_W-1:0] DIR_PRIO [4] = '{24'hFFFFFF, 24'h000000, 24'hFAC688, 24'h053977};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [PACK_W-1:0]  cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PACK_W-1:0]  in_refill_counts = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RUN_W-1:0]   out_running_task;
  logic               out_switched;
  logic [FIELD_W-1:0] out_remaining_slice;
  logic               out_reloaded;

  int fail_count;
  int pending;
  int checked;
  int reloads;
  int switches;
  int ticks_sent = 0;
  int settings = 1;
  int burst_left = 0;
  int max_gap = 4;
  int idle_cycles = 0;
  int squeeze_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  priority_timeslice_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_refill_counts    (in_refill_counts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_running_task    (out_running_task),
    .out_switched        (out_switched),
    .out_remaining_slice (out_remaining_slice),
    .out_reloaded        (out_reloaded)
  );

  sched_checker u_sched_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_refill_counts    (in_refill_counts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_running_task    (out_running_task),
    .out_switched        (out_switched),
    .out_remaining_slice (out_remaining_slice),
    .out_reloaded        (out_reloaded),
    .fail_count          (fail_count),
    .pending             (pending),
    .checked             (checked),
    .reloads             (reloads),
    .switches            (switches)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall modes of random length, plus long holds on request
  initial begin
    int cyc;
    int mode;
    int mode_left;
    int holds_done;
    cyc        = 0;
    mode       = 0;
    mode_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (squeeze_count > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  task automatic push_tick(input logic [PACK_W-1:0] refill);
    in_valid         <= 1'b1;
    in_refill_counts <= refill;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, max_gap)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic write_priorities(input logic [PACK_W-1:0] prio);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= prio;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  function automatic logic [PACK_W-1:0] random_refill();
    logic [PACK_W-1:0] w;
    int                sel;
    w   = PACK_W'($urandom);
    sel = $urandom_range(0, 9);
    if (sel >= 5) begin
      for (int t = 0; t < FIELDS; t++)
        w[FIELD_W*t +: FIELD_W] = (sel >= 8) ? FIELD_W'($urandom_range(1, 2))
                                              : FIELD_W'($urandom_range(1, 5));
    end
    return w;
  endfunction

  function automatic logic [PACK_W-1:0] random_priorities();
    logic [PACK_W-1:0]  w;
    logic [FIELD_W-1:0] same;
    w    = PACK_W'($urandom);
    same = FIELD_W'($urandom_range(0, 7));
    case ($urandom_range(0, 2))
      0: ;
      1: for (int t = 0; t < FIELDS; t++) w[FIELD_W*t +: FIELD_W] = FIELD_W'($urandom_range(1, 5));
      default: for (int t = 0; t < FIELDS; t++) w[FIELD_W*t +: FIELD_W] = same;
    endcase
    return w;
  endfunction

  initial begin
    int k;
    k = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset priorities first, then extreme settings
    for (int i = 0; i < N_DIR; i++) begin
      if (k < 4 && i == DIR_CUT[k]) begin
        write_priorities(DIR_PRIO[k]);
        k++;
      end
      push_tick(DIR_REFILL[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_priorities(random_priorities());
      max_gap = (p % 4 == 3) ? 1 : 24;
      if (p == 2 || p == 7) squeeze_count <= squeeze_count + 1;
      for (int n = 0; n < PHASE_TICKS; n++) push_tick(random_refill());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);

    $display("Ran %0d ticks under %0d priority settings, %0d results compared.",
             ticks_sent, settings, checked);
    $display("Saw %0d slice reloads, %0d task switches and %0d long receiver holds.",
             reloads, switches, squeeze_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pts_pkg.sv
sv/pts_ctrl.sv
sv/pts_dp.sv
sv/priority_timeslice_scheduler.sv
sv/pts_checker.sv
dv/sched_checker.sv
dv/testbench.sv
